// ===== src/hmtp_pkg.sv =====
// Shared types, codes and constants for the height map token parser.
`timescale 1ns / 1ps
`default_nettype none

package hmtp_pkg;

    localparam int unsigned MAX_COLUMNS_DEF = 1024;
    localparam int unsigned MAX_ROWS_DEF    = 1024;

    localparam logic [10:0] COLUMN_COUNT_RST = 11'd1024;
    localparam logic [31:0] COLOR_DEFAULT    = 32'h00FF_FFFF;
    localparam logic [31:0] MAG_CAP          = 32'h8000_0000;
    localparam logic [31:0] HEIGHT_MAX       = 32'h7FFF_FFFF;
    localparam logic [3:0]  HEX_DIGITS_MAX   = 4'd8;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_MINUS  = 3'd1;
    localparam logic [2:0] PH_DIGITS = 3'd2;
    localparam logic [2:0] PH_COMMA  = 3'd3;
    localparam logic [2:0] PH_ZERO   = 3'd4;
    localparam logic [2:0] PH_HEX    = 3'd5;
    localparam logic [2:0] PH_BAD    = 3'd6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_TOK = 2'd1;
    localparam logic [1:0] ST_BAD_COL = 2'd2;

    typedef struct packed {
        logic [2:0]  phase;
        logic        negative;
        logic [31:0] height_acc;
        logic [31:0] color_acc;
        logic [3:0]  hex_digits;
        logic [10:0] column_counter;
        logic [9:0]  row_counter;
        logic        failed;
    } parse_state_t;

    typedef struct packed {
        logic [31:0] height;
        logic [31:0] color;
        logic [9:0]  column;
        logic [9:0]  row;
        logic [1:0]  status;
        logic        row_last;
    } token_result_t;

endpackage

`default_nettype wire

// ===== src/hmtp_core.sv =====
// Next-state and token result logic for one accepted text byte.
`timescale 1ns / 1ps
`default_nettype none

module hmtp_core #(
    parameter int unsigned MAX_COLUMNS = hmtp_pkg::MAX_COLUMNS_DEF,
    parameter int unsigned MAX_ROWS    = hmtp_pkg::MAX_ROWS_DEF
) (
    input  wire hmtp_pkg::parse_state_t  cur,
    input  wire logic [7:0]              char_in,
    input  wire logic                    line_end,
    input  wire logic [10:0]             column_count,
    output hmtp_pkg::parse_state_t       nxt,
    output logic                         emit,
    output hmtp_pkg::token_result_t      res
);

    localparam bit          COL_CAPPED = (MAX_COLUMNS < 2048);
    localparam logic [10:0] COL_LIM    = COL_CAPPED ? 11'(MAX_COLUMNS) : 11'h7FF;
    localparam logic [9:0]  ROW_TOP    = 10'(((MAX_ROWS < 1024) ? MAX_ROWS : 1024) - 1);

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    logic        is_space;
    logic        is_digit;
    logic [3:0]  digit;
    logic [4:0]  hv;
    logic [35:0] dec_sum;
    logic [31:0] dec_acc;
    logic        finish;
    logic        tok_ok;
    logic [10:0] limit;
    logic [1:0]  status;
    logic [31:0] height_val;

    always_comb begin
        is_space = (char_in == 8'h20);
        is_digit = (char_in >= 8'h30) && (char_in <= 8'h39);
        digit    = char_in[3:0];
        hv       = hex_value(char_in);
        dec_sum  = ({4'd0, cur.height_acc} << 3) + ({4'd0, cur.height_acc} << 1)
                 + {32'd0, digit};
        dec_acc  = (dec_sum > {4'd0, hmtp_pkg::MAG_CAP}) ? hmtp_pkg::MAG_CAP : dec_sum[31:0];

        nxt = cur;
        if (!is_space) begin
            case (cur.phase)
                hmtp_pkg::PH_IDLE: begin
                    if (char_in == 8'h2D) begin
                        nxt.phase    = hmtp_pkg::PH_MINUS;
                        nxt.negative = 1'b1;
                    end else if (is_digit) begin
                        nxt.phase      = hmtp_pkg::PH_DIGITS;
                        nxt.height_acc = dec_acc;
                    end else if (char_in == 8'h2C) begin
                        nxt.phase = hmtp_pkg::PH_COMMA;
                    end else begin
                        nxt.phase = hmtp_pkg::PH_BAD;
                    end
                end
                hmtp_pkg::PH_MINUS: begin
                    if (is_digit) begin
                        nxt.phase      = hmtp_pkg::PH_DIGITS;
                        nxt.height_acc = dec_acc;
                    end else begin
                        nxt.phase = hmtp_pkg::PH_BAD;
                    end
                end
                hmtp_pkg::PH_DIGITS: begin
                    if (is_digit) begin
                        nxt.height_acc = dec_acc;
                    end else if (char_in == 8'h2C) begin
                        nxt.phase = hmtp_pkg::PH_COMMA;
                    end else begin
                        nxt.phase = hmtp_pkg::PH_BAD;
                    end
                end
                hmtp_pkg::PH_COMMA: begin
                    nxt.phase = (char_in == 8'h30) ? hmtp_pkg::PH_ZERO : hmtp_pkg::PH_BAD;
                end
                hmtp_pkg::PH_ZERO: begin
                    nxt.phase = (char_in == 8'h78) ? hmtp_pkg::PH_HEX : hmtp_pkg::PH_BAD;
                end
                hmtp_pkg::PH_HEX: begin
                    if (!hv[4] || cur.hex_digits >= hmtp_pkg::HEX_DIGITS_MAX) begin
                        nxt.phase = hmtp_pkg::PH_BAD;
                    end else begin
                        nxt.color_acc  = {cur.color_acc[27:0], hv[3:0]};
                        nxt.hex_digits = cur.hex_digits + 4'd1;
                    end
                end
                default: begin
                    nxt.phase = hmtp_pkg::PH_BAD;
                end
            endcase
        end

        finish = is_space ? (cur.phase != hmtp_pkg::PH_IDLE) : line_end;

        // status from the phase reached after this byte
        tok_ok = (nxt.phase == hmtp_pkg::PH_DIGITS)
              || (nxt.phase == hmtp_pkg::PH_HEX && nxt.hex_digits != 4'd0
                  && nxt.color_acc != 32'd0);
        limit  = (COL_CAPPED && column_count > COL_LIM) ? COL_LIM : column_count;
        if (!tok_ok) begin
            status = hmtp_pkg::ST_BAD_TOK;
        end else if (nxt.column_counter >= limit) begin
            status = hmtp_pkg::ST_BAD_COL;
        end else begin
            status = hmtp_pkg::ST_OK;
        end

        if (nxt.negative) begin
            height_val = 32'd0 - nxt.height_acc;
        end else if (nxt.height_acc >= hmtp_pkg::MAG_CAP) begin
            height_val = hmtp_pkg::HEIGHT_MAX;
        end else begin
            height_val = nxt.height_acc;
        end

        res.height   = (status == hmtp_pkg::ST_OK) ? height_val : 32'd0;
        res.color    = (status != hmtp_pkg::ST_OK) ? 32'd0
                     : (nxt.phase == hmtp_pkg::PH_HEX) ? nxt.color_acc
                     : hmtp_pkg::COLOR_DEFAULT;
        res.column   = nxt.column_counter[9:0];
        res.row      = nxt.row_counter;
        res.status   = status;
        res.row_last = line_end;

        if (finish) begin
            if (status != hmtp_pkg::ST_OK) begin
                nxt.failed = 1'b1;
            end
            if (nxt.column_counter < 11'h7FF) begin
                nxt.column_counter = nxt.column_counter + 11'd1;
            end
            nxt.phase      = hmtp_pkg::PH_IDLE;
            nxt.negative   = 1'b0;
            nxt.height_acc = 32'd0;
            nxt.color_acc  = 32'd0;
            nxt.hex_digits = 4'd0;
        end

        if (line_end && !nxt.failed) begin
            nxt.column_counter = 11'd0;
            if (nxt.row_counter < ROW_TOP) begin
                nxt.row_counter = nxt.row_counter + 10'd1;
            end
        end

        emit = finish && !cur.failed;
        if (cur.failed) begin
            nxt = cur;
        end
    end

endmodule

`default_nettype wire

// ===== src/height_map_token_parser.sv =====
// Top level of the height map token parser: state, config and result registers.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid / s_ready  s_char_in, s_line_end
//   m_       out        m_valid / m_ready  m_height, m_color, m_column, m_row,
//                                          m_status, m_row_last
//
// One byte is taken every cycle while s_ready is high; the parse state updates on the accepting edge.
// A finished token shows on m_ in the cycle after the transfer of the byte that ends it.
// s_ready drops only while a result is held and m_ready is low.
// Synchronous active-low reset clears the parse state and sets column_count to 1024.
// After an error result, bytes are still taken and dropped until reset.
`timescale 1ns / 1ps
`default_nettype none

module height_map_token_parser #(
    parameter int unsigned MAX_COLUMNS = hmtp_pkg::MAX_COLUMNS_DEF,
    parameter int unsigned MAX_ROWS    = hmtp_pkg::MAX_ROWS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [10:0]        cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_char_in,
    input  wire logic               s_line_end,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_height,
    output logic [31:0]             m_color,
    output logic [9:0]              m_column,
    output logic [9:0]              m_row,
    output logic [1:0]              m_status,
    output logic                    m_row_last
);

    hmtp_pkg::parse_state_t  state_reg;
    hmtp_pkg::parse_state_t  state_next;
    hmtp_pkg::token_result_t res_reg;
    hmtp_pkg::token_result_t res_next;
    logic [10:0]             column_count_reg;
    logic                    m_valid_reg;
    logic                    emit;
    logic                    s_xfer;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    hmtp_core #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_core (
        .cur         (state_reg),
        .char_in     (s_char_in),
        .line_end    (s_line_end),
        .column_count(column_count_reg),
        .nxt         (state_next),
        .emit        (emit),
        .res         (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= '0;
            column_count_reg <= hmtp_pkg::COLUMN_COUNT_RST;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                column_count_reg <= cfg_wr_data;
            end
            if (s_xfer) begin
                state_reg <= state_next;
            end
            if (s_xfer && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && emit) begin
            res_reg <= res_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_height   = $signed(res_reg.height);
    assign m_color    = res_reg.color;
    assign m_column   = res_reg.column;
    assign m_row      = res_reg.row;
    assign m_status   = res_reg.status;
    assign m_row_last = res_reg.row_last;

`ifndef SYNTHESIS
    a_no_result_after_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.failed |=> !$rose(m_valid))
        else $error("result issued after parser failure");

    a_error_sets_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != hmtp_pkg::ST_OK |-> state_reg.failed)
        else $error("error result without failed state");

    a_ok_color_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == hmtp_pkg::ST_OK |-> m_color != 32'd0)
        else $error("ok result with zero color");

    a_fail_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.failed |=> state_reg.failed && $stable(state_reg.row_counter))
        else $error("parse state moved after failure");
`endif

endmodule

`default_nettype wire

// ===== dv/hmtp_checker.sv =====
// Checker for the height map token parser: predicts each token result and compares it.
`timescale 1ns / 1ps

module hmtp_checker #(
    parameter int unsigned MAX_COLUMNS = hmtp_pkg::MAX_COLUMNS_DEF,
    parameter int unsigned MAX_ROWS    = hmtp_pkg::MAX_ROWS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [10:0]        cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_char_in,
    input  logic               s_line_end,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_height,
    input  logic [31:0]        m_color,
    input  logic [9:0]         m_column,
    input  logic [9:0]         m_row,
    input  logic [1:0]         m_status,
    input  logic               m_row_last,
    output int                 fail_count,
    output int                 tokens_due
);

    logic [10:0]             columns_allowed;
    logic [2:0]              phase;
    logic                    negative;
    logic [31:0]             magnitude;
    logic [31:0]             hue;
    logic [3:0]              hex_count;
    logic [10:0]             column;
    logic [9:0]              row;
    logic                    halted;
    hmtp_pkg::token_result_t due_q[$];
    int                      faults = 0;

    function automatic logic [31:0] times_ten_plus(input logic [31:0] m, input logic [7:0] c);
        logic [35:0] wide;
        wide = {4'd0, m} * 36'd10 + {32'd0, c[3:0]};
        return (wide > {4'd0, hmtp_pkg::MAG_CAP}) ? hmtp_pkg::MAG_CAP : wide[31:0];
    endfunction

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    task automatic absorb_char(input logic [7:0] c);
        logic digit;
        int   nib;
        digit = (c >= "0" && c <= "9");
        case (phase)
            hmtp_pkg::PH_IDLE: begin
                if (c == "-") begin
                    phase    = hmtp_pkg::PH_MINUS;
                    negative = 1'b1;
                end else if (digit) begin
                    phase     = hmtp_pkg::PH_DIGITS;
                    magnitude = times_ten_plus(magnitude, c);
                end else if (c == ",") begin
                    phase = hmtp_pkg::PH_COMMA;
                end else begin
                    phase = hmtp_pkg::PH_BAD;
                end
            end
            hmtp_pkg::PH_MINUS: begin
                if (digit) begin
                    phase     = hmtp_pkg::PH_DIGITS;
                    magnitude = times_ten_plus(magnitude, c);
                end else begin
                    phase = hmtp_pkg::PH_BAD;
                end
            end
            hmtp_pkg::PH_DIGITS: begin
                if (digit) begin
                    magnitude = times_ten_plus(magnitude, c);
                end else if (c == ",") begin
                    phase = hmtp_pkg::PH_COMMA;
                end else begin
                    phase = hmtp_pkg::PH_BAD;
                end
            end
            hmtp_pkg::PH_COMMA: begin
                phase = (c == "0") ? hmtp_pkg::PH_ZERO : hmtp_pkg::PH_BAD;
            end
            hmtp_pkg::PH_ZERO: begin
                phase = (c == "x") ? hmtp_pkg::PH_HEX : hmtp_pkg::PH_BAD;
            end
            hmtp_pkg::PH_HEX: begin
                nib = nibble_of(c);
                if (nib < 0 || hex_count >= hmtp_pkg::HEX_DIGITS_MAX) begin
                    phase = hmtp_pkg::PH_BAD;
                end else begin
                    hue       = {hue[27:0], nib[3:0]};
                    hex_count = hex_count + 4'd1;
                end
            end
            default: begin
                phase = hmtp_pkg::PH_BAD;
            end
        endcase
    endtask

    task automatic close_token(input logic last);
        hmtp_pkg::token_result_t t;
        int unsigned             limit;
        limit    = (columns_allowed < MAX_COLUMNS) ? columns_allowed : MAX_COLUMNS;
        t.status = hmtp_pkg::ST_OK;
        t.color  = hmtp_pkg::COLOR_DEFAULT;
        if (phase == hmtp_pkg::PH_HEX) begin
            t.color = hue;
            if (hex_count == 4'd0 || hue == 32'd0) t.status = hmtp_pkg::ST_BAD_TOK;
        end else if (phase != hmtp_pkg::PH_DIGITS && phase != hmtp_pkg::PH_COMMA) begin
            t.status = hmtp_pkg::ST_BAD_TOK;
        end
        if (phase == hmtp_pkg::PH_COMMA && hex_count == 4'd0) t.status = hmtp_pkg::ST_BAD_TOK;
        if (t.status == hmtp_pkg::ST_OK && column >= limit) t.status = hmtp_pkg::ST_BAD_COL;
        if (negative) begin
            t.height = 32'd0 - magnitude;
        end else begin
            t.height = (magnitude >= hmtp_pkg::MAG_CAP) ? hmtp_pkg::HEIGHT_MAX : magnitude;
        end
        if (t.status != hmtp_pkg::ST_OK) begin
            t.height = 32'd0;
            t.color  = 32'd0;
            halted   = 1'b1;
        end
        t.column   = column[9:0];
        t.row      = row;
        t.row_last = last;
        due_q.push_back(t);
        if (column != 11'h7FF) column = column + 11'd1;
        phase     = hmtp_pkg::PH_IDLE;
        negative  = 1'b0;
        magnitude = 32'd0;
        hue       = 32'd0;
        hex_count = 4'd0;
    endtask

    task automatic close_line();
        int unsigned top_row;
        top_row = ((MAX_ROWS < 1024) ? MAX_ROWS : 1024) - 1;
        column  = 11'd0;
        if (row < top_row) row = row + 10'd1;
    endtask

    task automatic take_byte(input logic [7:0] c, input logic last);
        if (!halted) begin
            if (c == " ") begin
                if (phase != hmtp_pkg::PH_IDLE) close_token(last);
            end else begin
                absorb_char(c);
                if (last) close_token(last);
            end
            if (last && !halted) close_line();
        end
    endtask

    task automatic compare_result();
        hmtp_pkg::token_result_t want;
        logic                    off;
        if (due_q.size() == 0) begin
            faults++;
            if (faults <= 10) begin
                $display("%0t: unexpected token result h=%0d c=%h col=%0d row=%0d st=%0d last=%0d",
                         $time, m_height, m_color, m_column, m_row, m_status, m_row_last);
            end
        end else begin
            want = due_q.pop_front();
            off  = (m_height !== want.height) || (m_color !== want.color)
                || (m_column !== want.column) || (m_row !== want.row)
                || (m_status !== want.status) || (m_row_last !== want.row_last);
            if (off) begin
                faults++;
                if (faults <= 10) begin
                    $display("%0t: token mismatch", $time);
                    $display("  want h=%0d c=%h col=%0d row=%0d st=%0d last=%0d",
                             $signed(want.height), want.color, want.column, want.row,
                             want.status, want.row_last);
                    $display("  got  h=%0d c=%h col=%0d row=%0d st=%0d last=%0d",
                             m_height, m_color, m_column, m_row, m_status, m_row_last);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            columns_allowed = hmtp_pkg::COLUMN_COUNT_RST;
            phase           = hmtp_pkg::PH_IDLE;
            negative        = 1'b0;
            magnitude       = 32'd0;
            hue             = 32'd0;
            hex_count       = 4'd0;
            column          = 11'd0;
            row             = 10'd0;
            halted          = 1'b0;
            due_q.delete();
        end else begin
            if (m_valid && m_ready) compare_result();
            if (s_valid && s_ready) take_byte(s_char_in, s_line_end);
            if (cfg_wr_en) columns_allowed = cfg_wr_data;
        end
        fail_count <= faults;
        tokens_due <= due_q.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the height map token parser: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_BYTES   = 750;

    logic               aclk;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [10:0]        cfg_wr_data = 11'd0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [7:0]         s_char_in   = 8'd0;
    logic               s_line_end  = 1'b0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic signed [31:0] m_height;
    logic [31:0]        m_color;
    logic [9:0]         m_column;
    logic [9:0]         m_row;
    logic [1:0]         m_status;
    logic               m_row_last;

    int         fail_count;
    int         tokens_due;
    int         idle_cycles = 0;
    int         stall_left  = 0;
    int         bytes_sent  = 0;
    int         columns     = 1024;
    bit         steady      = 1'b0;
    logic [7:0] text[$];

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    height_map_token_parser uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_in   (s_char_in),
        .s_line_end  (s_line_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_height    (m_height),
        .m_color     (m_color),
        .m_column    (m_column),
        .m_row       (m_row),
        .m_status    (m_status),
        .m_row_last  (m_row_last)
    );

    hmtp_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_in   (s_char_in),
        .s_line_end  (s_line_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_height    (m_height),
        .m_color     (m_color),
        .m_column    (m_column),
        .m_row       (m_row),
        .m_status    (m_status),
        .m_row_last  (m_row_last),
        .fail_count  (fail_count),
        .tokens_due  (tokens_due)
    );

    // result side back-pressure
    always @(posedge aclk) begin : rx_pace
        int draw;
        draw = $urandom_range(0, 99);
        if (steady) begin
            m_ready    <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (draw < 80) begin
            m_ready <= 1'b1;
        end else if (draw < 97) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(14, 39);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int sender_gap();
        int draw;
        draw = $urandom_range(0, 99);
        if (steady || draw < 60) return 0;
        if (draw < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] hex_char(input int nib);
        if (nib < 10) return 8'(int'("0") + nib);
        if ($urandom_range(0, 1) != 0) return 8'(int'("a") + nib - 10);
        return 8'(int'("A") + nib - 10);
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        gap = sender_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_char_in  <= c;
        s_line_end <= last;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // one line: line_end rides on its final byte
    task automatic send_text();
        int i;
        for (i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
        text.delete();
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tokens_due != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_columns(input int v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[10:0];
        columns     = v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic put_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++) text.push_back(s[i]);
    endtask

    task automatic put_spaces(input int n);
        repeat (n) text.push_back(" ");
    endtask

    task automatic put_good_token();
        int ndig;
        int nhex;
        int nib;
        int i;
        bit has_color;
        bit all_zero;
        has_color = ($urandom_range(0, 9) < 4);
        ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
        if (has_color && $urandom_range(0, 4) == 0) ndig = 0;
        if (ndig != 0 && $urandom_range(0, 2) == 0) text.push_back("-");
        repeat (ndig) text.push_back(hex_char($urandom_range(0, 9)));
        if (has_color) begin
            put_str(",0x");
            nhex     = $urandom_range(1, 8);
            all_zero = 1'b1;
            for (i = 0; i < nhex; i++) begin
                nib = $urandom_range(0, 15);
                if (i == nhex - 1 && all_zero && nib == 0) nib = $urandom_range(1, 15);
                if (nib != 0) all_zero = 1'b0;
                text.push_back(hex_char(nib));
            end
        end
    endtask

    task automatic put_bad_token();
        logic [7:0] ch;
        case ($urandom_range(0, 9))
            0: put_str("-");
            1: put_str("12,");
            2: put_str(",0");
            3: put_str("7,0x");
            4: put_str("3,0X1F");
            5: put_str("1,0x123456789");
            6: put_str("-5,0x00");
            7: put_str("4-2");
            8: put_str("--1");
            default: begin
                do ch = 8'($urandom_range(0, 255));
                while (ch == " " || ch == "-" || ch == "," || (ch >= "0" && ch <= "9"));
                text.push_back(ch);
            end
        endcase
    endtask

    task automatic put_line(input int most);
        int n;
        int k;
        n = $urandom_range(0, (columns < most) ? columns : most);
        put_spaces($urandom_range(0, 2));
        for (k = 0; k < n; k++) begin
            if (k != 0) put_spaces($urandom_range(1, 3));
            put_good_token();
        end
        if (n == 0 || $urandom_range(0, 1) != 0) put_spaces($urandom_range(1, 2));
        send_text();
    endtask

    initial begin : stimulus
        int start;
        int phase_start;
        int round;
        int kind;
        int c;
        int n;
        int k;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        put_str("0 -0 2147483647 -2147483648 2147483648 0000000000042 99999999999");
        send_text();
        put_str("-99999999999 ,0x1 7,0xFFFFFFFF -12,0xaBcDeF01 ");
        send_text();
        put_str(" ");
        send_text();
        put_str("5");
        send_text();
        put_str("  8   9,0x00000010");
        send_text();

        start = bytes_sent;
        round = 0;
        while (bytes_sent - start < RANDOM_BYTES) begin
            case (round)
                0: c = 1;
                1: c = 1023;
                2: c = 2;
                default: c = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8)
                                                         : $urandom_range(1, 1024);
            endcase
            set_columns(c);
            steady      = ($urandom_range(0, 3) == 0);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 150) begin
                put_line(6);
                if ($urandom_range(0, 19) == 0) settle();
            end
            round++;
        end
        steady = 1'b0;

        set_columns(1024);
        repeat (3) put_line(6);

        // single error; the parser stays dead afterwards
        kind = $urandom_range(0, 2);
        c    = (kind == 0) ? 1024 : $urandom_range(1, 4);
        set_columns(c);
        n = (kind == 0) ? $urandom_range(0, 3) : c;
        for (k = 0; k < n; k++) begin
            if (k != 0) put_str(" ");
            put_good_token();
        end
        if (n != 0) put_str(" ");
        if (kind == 1) put_good_token();
        else put_bad_token();
        if ($urandom_range(0, 1) != 0) put_str(" ");
        send_text();

        for (k = 0; k < 100; k++) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 1));
        settle();

        if (fail_count == 0 && tokens_due == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
